/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the top-level design file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ged_pkg.sv */
// ----------------------------------------------------------------------------
// ged_pkg
// Shared constants, types and the correction function of the dither block.
// ----------------------------------------------------------------------------
package ged_pkg;

  // line store depth and column counter width
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);

  localparam int PIX_W      = 8;
  localparam int ERR_W      = 8;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 16;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;
  localparam int REG_IDX_LSB = 2;

  // compare width for column + 1 against the clamped row width
  localparam int WCMP_W = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;

  // luma: (299 R + 587 G + 114 B + 500) / 1000
  localparam int SUM_W   = 18;
  localparam int RECIP_W = 19;
  localparam int RECIP_SHIFT = 28;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam logic [SUM_W-1:0] COEF_R    = SUM_W'(299);
  localparam logic [SUM_W-1:0] COEF_G    = SUM_W'(587);
  localparam logic [SUM_W-1:0] COEF_B    = SUM_W'(114);
  localparam logic [SUM_W-1:0] ROUND_OFS = SUM_W'(500);
  // ceil(2^28 / 1000); exact floor for every sum below 2^28 / 544
  localparam logic [RECIP_W-1:0] GRAY_RECIP = RECIP_W'(268436);

  localparam logic [PIX_W-1:0] WHITE_THRESHOLD = PIX_W'(127);

  // register map (word index)
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);

  typedef struct packed {
    logic row_nz;   // not the first row
    logic col_nz;   // not the first column
    logic eor;      // last pixel of row
    logic eof;      // last pixel of frame
  } ged_flags_t;

  // clamp(floor((8 v + k e + 4) / 8), 0, 255), k = 3 when k3 else 2
  function automatic logic [PIX_W-1:0] apply_corr(input logic [PIX_W-1:0] v,
                                                  input logic [ERR_W-1:0] e,
                                                  input logic k3);
    logic signed [12:0] ex;
    logic signed [12:0] ke;
    logic signed [12:0] n;
    logic signed [9:0]  q;
    logic [PIX_W-1:0]   res;
    ex = {{5{e[ERR_W-1]}}, e};
    ke = ex <<< 1;
    if (k3) begin
      ke = ke + ex;
    end
    n = $signed({2'b00, v, 3'b000}) + ke + 13'sd4;
    q = n[12:3];
    if (q < 10'sd0) begin
      res = '0;
    end else if (q > 10'sd255) begin
      res = '1;
    end else begin
      res = q[PIX_W-1:0];
    end
    return res;
  endfunction

endpackage

/* design/ged_line_mem.sv */
// ----------------------------------------------------------------------------
// ged_line_mem
// Error line store: one entry per column, one write and one registered read.
// ----------------------------------------------------------------------------
module ged_line_mem (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [ged_pkg::COL_W-1:0] rd_addr,
  output logic [ged_pkg::ERR_W-1:0] rd_data,
  input  logic                      wr_en,
  input  logic [ged_pkg::COL_W-1:0] wr_addr,
  input  logic [ged_pkg::ERR_W-1:0] wr_data
);
  import ged_pkg::*;

  logic [ERR_W-1:0] mem [MAX_WIDTH];
  logic [ERR_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read-first; same-edge write is forwarded by the caller
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/ged_luma.sv */
// ----------------------------------------------------------------------------
// ged_luma
// Two-stage RGB to gray: weighted sum, then divide by 1000 via reciprocal.
// ----------------------------------------------------------------------------
module ged_luma (
  input  logic                      clk,
  input  logic                      load_sum,
  input  logic                      load_gray,
  input  logic [ged_pkg::PIX_W-1:0] red,
  input  logic [ged_pkg::PIX_W-1:0] green,
  input  logic [ged_pkg::PIX_W-1:0] blue,
  output logic [ged_pkg::PIX_W-1:0] gray
);
  import ged_pkg::*;

  logic [SUM_W-1:0]  sum_nxt;
  logic [SUM_W-1:0]  sum_r;
  logic [PROD_W-1:0] prod;
  logic [PIX_W-1:0]  gray_r;

  assign sum_nxt = SUM_W'(red) * COEF_R + SUM_W'(green) * COEF_G
                 + SUM_W'(blue) * COEF_B + ROUND_OFS;

  assign prod = PROD_W'(sum_r) * PROD_W'(GRAY_RECIP);

  always_ff @(posedge clk) begin
    if (load_sum) begin
      sum_r <= sum_nxt;
    end
    if (load_gray) begin
      gray_r <= prod[RECIP_SHIFT +: PIX_W];
    end
  end

  assign gray = gray_r;

endmodule

/* design/ged_diffuse.sv */
// ----------------------------------------------------------------------------
// ged_diffuse
// Applies the three neighbor corrections, thresholds, and keeps left and upper-left errors.
// ----------------------------------------------------------------------------
module ged_diffuse (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      commit,
  input  logic [ged_pkg::PIX_W-1:0] gray,
  input  logic [ged_pkg::ERR_W-1:0] above,
  input  ged_pkg::ged_flags_t       flags,
  output logic                      white,
  output logic [ged_pkg::ERR_W-1:0] err
);
  import ged_pkg::*;

  logic [ERR_W-1:0] left_err_r;
  logic [ERR_W-1:0] upper_err_r;
  logic [PIX_W-1:0] v_diag;
  logic [PIX_W-1:0] v_up;
  logic [PIX_W-1:0] v_left;

  always_comb begin
    v_diag = (flags.row_nz && flags.col_nz) ? apply_corr(gray, upper_err_r, 1'b0) : gray;
    v_up   = flags.row_nz ? apply_corr(v_diag, above, 1'b1) : v_diag;
    v_left = flags.col_nz ? apply_corr(v_up, left_err_r, 1'b1) : v_up;
  end

  // white: v - 255 in 8 bits equals v + 1
  assign white = (v_left > WHITE_THRESHOLD);
  assign err   = white ? v_left + PIX_W'(1) : v_left;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_err_r  <= '0;
      upper_err_r <= '0;
    end else if (commit) begin
      if (flags.eor) begin
        left_err_r  <= '0;
        upper_err_r <= '0;
      end else begin
        left_err_r  <= err;
        upper_err_r <= above;
      end
    end
  end

endmodule

/* design/gray_error_diffusion_dither.sv */
// A transaction accepted on in_* reaches out_* through, in order: luma sum and line read,
// divide and above error into stage 2, diffuse into the output register.
// One pixel per cycle while out_ready lets the output drain; the left-error loop closes in the diffuse stage.
// Reset (rst_n, synchronous): valid bits, counters and carried errors clear,
// size returns to 640 x 480; the line store is not cleared and needs no pass.
// ----------------------------------------------------------------------------
// gray_error_diffusion_dither
// Streaming RGB to one-bit error-diffusion dither with an APB config port.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gray_error_diffusion_dither (
  input  logic                         clk,
  input  logic                         rst_n,
  // pixel input
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ged_pkg::PIX_W-1:0]    in_red,
  input  logic [ged_pkg::PIX_W-1:0]    in_green,
  input  logic [ged_pkg::PIX_W-1:0]    in_blue,
  // dithered output
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_pixel_white,
  output logic                         out_end_of_row,
  output logic                         out_end_of_frame,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ged_pkg::ADDR_W-1:0]   paddr,
  input  logic [ged_pkg::DATA_W-1:0]   pwdata,
  output logic [ged_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import ged_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [WIDTH_W-1:0]  cfg_width_r;
  logic [HEIGHT_W-1:0] cfg_height_r;
  logic                cfg_wr;
  logic                reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[REG_IDX_LSB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= WIDTH_RESET;
      cfg_height_r <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_IMAGE_WIDTH:  cfg_width_r  <= pwdata[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: cfg_height_r <= pwdata[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_IMAGE_WIDTH:  prdata = DATA_W'(cfg_width_r);
      REG_IMAGE_HEIGHT: prdata = DATA_W'(cfg_height_r);
      default:          prdata = '0;
    endcase
  end

  // Effective frame size: zero acts as one, width saturates at the line depth.
  logic [WCMP_W-1:0]   width_eff;
  logic [HEIGHT_W-1:0] height_eff;

  always_comb begin
    width_eff = WCMP_W'(cfg_width_r);
    if (width_eff == '0) begin
      width_eff = WCMP_W'(1);
    end else if (width_eff > WCMP_W'(MAX_WIDTH)) begin
      width_eff = WCMP_W'(MAX_WIDTH);
    end
    height_eff = (cfg_height_r == '0) ? HEIGHT_W'(1) : cfg_height_r;
  end

  // --------------------------------------------------------------------------
  // Pipeline control: stage 1 (sum, line read), stage 2 (diffuse), output.
  // A stage takes new data when it is empty or its content moves on, so
  // bubbles collapse and intake continues while a result waits.
  // --------------------------------------------------------------------------
  logic s1_valid_r;
  logic s2_valid_r;
  logic out_valid_r;
  logic out_free;
  logic s2_go;
  logic s2_free;
  logic s1_go;
  logic s1_free;
  logic accept;

  assign out_free = !out_valid_r || out_ready;
  assign s2_go    = s2_valid_r && out_free;
  assign s2_free  = !s2_valid_r || out_free;
  assign s1_go    = s1_valid_r && s2_free;
  assign s1_free  = !s1_valid_r || s2_free;
  assign in_ready = s1_free;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_r <= accept;
      end
      if (s2_free) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s2_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Raster position, advanced per accepted transaction
  // --------------------------------------------------------------------------
  logic [COL_W-1:0]    col_r;
  logic [HEIGHT_W-1:0] row_r;
  ged_flags_t          in_flags;

  always_comb begin
    in_flags.row_nz = (row_r != '0);
    in_flags.col_nz = (col_r != '0);
    in_flags.eor    = (WCMP_W'(col_r) + WCMP_W'(1) >= width_eff);
    in_flags.eof    = in_flags.eor &&
                      ({1'b0, row_r} + (HEIGHT_W+1)'(1) >= {1'b0, height_eff});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      if (in_flags.eor) begin
        col_r <= '0;
        row_r <= in_flags.eof ? '0 : row_r + HEIGHT_W'(1);
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Luma and line store
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] gray;
  logic [ERR_W-1:0] mem_rd_data;
  logic             diff_white;
  logic [ERR_W-1:0] diff_err;
  logic [COL_W-1:0] s1_col_r;
  logic [COL_W-1:0] s2_col_r;
  ged_flags_t       s1_flags_r;
  ged_flags_t       s2_flags_r;
  logic [ERR_W-1:0] s2_above_r;

  ged_luma u_luma (
    .clk       (clk),
    .load_sum  (accept),
    .load_gray (s1_go),
    .red       (in_red),
    .green     (in_green),
    .blue      (in_blue),
    .gray      (gray)
  );

  ged_line_mem u_line_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_r),
    .rd_data (mem_rd_data),
    .wr_en   (s2_go),
    .wr_addr (s2_col_r),
    .wr_data (diff_err)
  );

  // Above-error forwarding. The read is issued at accept; a write to the same
  // column from an older pixel can land on that edge (read returns old data)
  // or on the edge that moves this pixel into stage 2. Both are caught here.
  logic             s1_fwd_hit_r;
  logic [ERR_W-1:0] s1_fwd_data_r;
  logic             wr_hits_s1;
  logic [ERR_W-1:0] s1_above;

  assign wr_hits_s1 = s2_go && (s2_col_r == s1_col_r);
  assign s1_above   = wr_hits_s1   ? diff_err :
                      s1_fwd_hit_r ? s1_fwd_data_r : mem_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_fwd_hit_r <= 1'b0;
    end else if (accept) begin
      s1_fwd_hit_r <= s2_go && (s2_col_r == col_r);
    end else if (s1_valid_r && wr_hits_s1) begin
      s1_fwd_hit_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col_r      <= col_r;
      s1_flags_r    <= in_flags;
      s1_fwd_data_r <= diff_err;
    end else if (s1_valid_r && wr_hits_s1) begin
      s1_fwd_data_r <= diff_err;
    end
    if (s1_go) begin
      s2_col_r   <= s1_col_r;
      s2_flags_r <= s1_flags_r;
      s2_above_r <= s1_above;
    end
  end

  // --------------------------------------------------------------------------
  // Diffuse stage and output register
  // --------------------------------------------------------------------------
  ged_diffuse u_diffuse (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (s2_go),
    .gray   (gray),
    .above  (s2_above_r),
    .flags  (s2_flags_r),
    .white  (diff_white),
    .err    (diff_err)
  );

  logic out_white_r;
  logic out_eor_r;
  logic out_eof_r;

  always_ff @(posedge clk) begin
    if (s2_go) begin
      out_white_r <= diff_white;
      out_eor_r   <= s2_flags_r.eor;
      out_eof_r   <= s2_flags_r.eof;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_white  = out_white_r;
  assign out_end_of_row   = out_eor_r;
  assign out_end_of_frame = out_eof_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_IMPLY(a_eof_on_eor, clk, rst_n, out_valid && out_end_of_frame, out_end_of_row, "end of frame without end of row")
  `ASSERT_NEXT(a_col_wrap, clk, rst_n, accept && in_flags.eor, col_r == '0, "column did not wrap after row end")
  `ASSERT_NEXT(a_above_fwd, clk, rst_n, s1_go && wr_hits_s1, s2_above_r == $past(diff_err), "above error not forwarded")
  `ASSERT_IMPLY(a_full_stall, clk, rst_n, s1_valid_r && s2_valid_r && out_valid_r && !out_ready, !in_ready, "intake while pipeline is full")

endmodule
